// ----- src/npt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npt_pkg
// Shared types and constants for the nearest point on triangle stream block.
// ----------------------------------------------------------------------------
package npt_pkg;

  localparam int COORD_BITS_DEF   = 32;
  localparam int MESH_ID_BITS_DEF = 16;
  localparam int TRI_ID_BITS_DEF  = 24;
  localparam int APB_ADDR_BITS    = 4;

  localparam logic [32:0] FRAC_ONE = 33'h1_0000_0000;

  typedef enum logic [1:0] {
    REG_QUERY_X = 2'd0,
    REG_QUERY_Y = 2'd1,
    REG_QUERY_Z = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] first_vx;
    logic signed [31:0] first_vy;
    logic signed [31:0] first_vz;
    logic signed [31:0] second_vx;
    logic signed [31:0] second_vy;
    logic signed [31:0] second_vz;
    logic signed [31:0] third_vx;
    logic signed [31:0] third_vy;
    logic signed [31:0] third_vz;
    logic [15:0]        mesh_id;
    logic [23:0]        tri_id;
    logic               start_query;
  } tri_item_t;

  typedef struct packed {
    logic               shrunk;
    logic signed [31:0] best_px;
    logic signed [31:0] best_py;
    logic signed [31:0] best_pz;
    logic [63:0]        best_dist_sq;
    logic [15:0]        best_mesh;
    logic [23:0]        best_tri;
    logic               found;
  } res_item_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [63:0]        dist_sq;
  } near_t;

  typedef enum logic {
    MDU_MUL = 1'b0,
    MDU_DIV = 1'b1
  } mdu_op_t;

  typedef struct packed {
    logic         start;
    mdu_op_t      op;
    logic [127:0] a;
    logic [127:0] b;
  } mdu_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] res;
  } mdu_rsp_t;

endpackage

// ----- src/npt_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npt_stream_if
// Valid/ready stream channel carrying one item per handshake.
// ----------------------------------------------------------------------------
interface npt_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/npt_mdu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npt_mdu
// Shared multiply/divide unit: signed 64x64 multiply over four 32x32 partial
// products, and a restoring Q0.32 fraction divide, one bit per cycle.
// ----------------------------------------------------------------------------
module npt_mdu (
  input  logic              clk,
  input  logic              rst,
  input  npt_pkg::mdu_req_t req,
  output npt_pkg::mdu_rsp_t rsp
);
  import npt_pkg::*;

  typedef enum logic [2:0] {M_IDLE, M_MUL, M_NEG, M_DIV, M_FIN} mstate_t;

  mstate_t      state;
  logic [127:0] acc;
  logic [127:0] den;
  logic [63:0]  ma;
  logic [63:0]  mb;
  logic         neg;
  logic [32:0]  quo;
  logic [4:0]   cnt;
  logic         done;

  logic [63:0]  amag;
  logic [63:0]  bmag;
  logic [31:0]  pa;
  logic [31:0]  pb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [127:0] rem2;
  logic         take;
  logic         a_le0;
  logic         b_le0;
  logic         a_ge_b;

  always_comb begin
    amag   = req.a[63] ? (64'd0 - req.a[63:0]) : req.a[63:0];
    bmag   = req.b[63] ? (64'd0 - req.b[63:0]) : req.b[63:0];
    pa     = cnt[1] ? ma[63:32] : ma[31:0];
    pb     = cnt[0] ? mb[63:32] : mb[31:0];
    pp     = 64'(pa) * 64'(pb);
    case (cnt[1:0])
      2'd0:    pp_sh = {64'd0, pp};
      2'd1:    pp_sh = {32'd0, pp, 32'd0};
      2'd2:    pp_sh = {32'd0, pp, 32'd0};
      default: pp_sh = {pp, 64'd0};
    endcase
    rem2   = {acc[126:0], 1'b0};
    take   = (rem2 >= den);
    a_le0  = req.a[127] || (req.a == 128'd0);
    b_le0  = req.b[127] || (req.b == 128'd0);
    a_ge_b = (req.a >= req.b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        M_IDLE: begin
          if (req.start) begin
            cnt <= '0;
            if (req.op == MDU_MUL) begin
              ma    <= amag;
              mb    <= bmag;
              neg   <= req.a[63] ^ req.b[63];
              acc   <= '0;
              state <= M_MUL;
            end else if (a_le0 || b_le0) begin
              acc  <= '0;
              done <= 1'b1;
            end else if (a_ge_b) begin
              acc  <= {95'd0, FRAC_ONE};
              done <= 1'b1;
            end else begin
              acc   <= req.a;
              den   <= req.b;
              quo   <= '0;
              state <= M_DIV;
            end
          end
        end
        M_MUL: begin
          acc <= acc + pp_sh;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd3) state <= M_NEG;
        end
        M_NEG: begin
          if (neg) acc <= 128'd0 - acc;
          done  <= 1'b1;
          state <= M_IDLE;
        end
        M_DIV: begin
          acc <= take ? (rem2 - den) : rem2;
          quo <= {quo[31:0], take};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) state <= M_FIN;
        end
        M_FIN: begin
          acc   <= {95'd0, quo};
          done  <= 1'b1;
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.res  = acc;

endmodule

// ----- src/npt_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npt_core
// Sequencer for one triangle: dot products, barycentric terms, region choice,
// fractions, interpolation and squared distance, products and divides on the shared unit.
// ----------------------------------------------------------------------------
module npt_core #(
  parameter int COORD_BITS = npt_pkg::COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  npt_pkg::tri_item_t item,
  input  logic [31:0]        query_x,
  input  logic [31:0]        query_y,
  input  logic [31:0]        query_z,
  output logic               done,
  output npt_pkg::near_t     near
);
  import npt_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int PW = COORD_BITS + 3;
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [PW-1:0] PMAX = {3'b000, CMAX};
  localparam logic signed [PW-1:0] PMIN = {3'b111, CMIN};

  typedef enum logic [2:0] {
    ST_IDLE, ST_DOT, ST_VPROD, ST_REGION, ST_PREP, ST_DIV, ST_ALONG, ST_DIST
  } state_t;

  typedef enum logic [2:0] {
    RG_A, RG_B, RG_C, RG_AB, RG_AC, RG_BC, RG_FACE
  } region_t;

  state_t  state;
  region_t region;
  region_t rg;

  logic signed [CW-1:0]  av [3];
  logic signed [CW-1:0]  bv [3];
  logic signed [CW-1:0]  cv [3];
  logic signed [CW-1:0]  qv [3];
  logic signed [63:0]    d [6];
  logic signed [127:0]   vv [3];
  logic signed [127:0]   wacc;
  logic signed [63:0]    dacc;
  logic signed [127:0]   num;
  logic signed [127:0]   den;
  logic [32:0]           tf [2];
  logic signed [PW-1:0]  p [3];
  logic signed [CW-1:0]  po [3];
  logic [63:0]           sum_sq;
  logic [2:0]            step;
  logic [1:0]            comp;
  logic                  fsel;
  logic                  pend;

  logic signed [CW-1:0]  ab [3];
  logic signed [CW-1:0]  ac [3];
  logic signed [CW-1:0]  bc [3];
  logic signed [CW-1:0]  ap [3];
  logic signed [CW-1:0]  bp [3];
  logic signed [CW-1:0]  cp [3];
  logic signed [CW-1:0]  la;
  logic signed [CW-1:0]  lb;
  logic signed [CW-1:0]  lc;
  logic signed [CW-1:0]  lq;

  logic signed [63:0]    e43;
  logic signed [63:0]    e56;
  logic signed [63:0]    dsum;
  logic signed [CW-1:0]  uop;
  logic signed [CW-1:0]  vop;
  logic signed [CW-1:0]  ev;
  logic [CW-1:0]         emag;
  logic [63:0]           rnd;
  logic [PW-1:0]         rr;
  logic signed [PW-1:0]  pcur;
  logic signed [CW-1:0]  pc;
  logic signed [CW:0]    diff;
  logic [CW:0]           dmag;
  logic [33:0]           m34;
  logic                  sat;
  logic [63:0]           sq;
  logic [64:0]           s65;

  npt_pkg::mdu_req_t mreq;
  npt_pkg::mdu_rsp_t mrsp;

  npt_mdu u_mdu (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  // lattice vectors
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      la    = av[i] >>> 2;
      lb    = bv[i] >>> 2;
      lc    = cv[i] >>> 2;
      lq    = qv[i] >>> 2;
      ab[i] = lb - la;
      ac[i] = lc - la;
      bc[i] = lc - lb;
      ap[i] = lq - la;
      bp[i] = lq - lb;
      cp[i] = lq - lc;
    end
  end

  // region choice
  always_comb begin
    e43 = d[3] - d[2];
    e56 = d[4] - d[5];
    if (d[0] <= 64'sd0 && d[1] <= 64'sd0) begin
      rg = RG_A;
    end else if (d[2] >= 64'sd0 && d[3] <= d[2]) begin
      rg = RG_B;
    end else if (vv[0] <= 128'sd0 && d[0] >= 64'sd0 && d[2] <= 64'sd0) begin
      rg = RG_AB;
    end else if (d[5] >= 64'sd0 && d[4] <= d[5]) begin
      rg = RG_C;
    end else if (vv[1] <= 128'sd0 && d[1] >= 64'sd0 && d[5] <= 64'sd0) begin
      rg = RG_AC;
    end else if (vv[2] <= 128'sd0 && e43 >= 64'sd0 && e56 >= 64'sd0) begin
      rg = RG_BC;
    end else begin
      rg = RG_FACE;
    end
  end

  // operand selection
  always_comb begin
    uop = step[0] ? ac[comp] : ab[comp];
    case (step[2:1])
      2'd0:    vop = ap[comp];
      2'd1:    vop = bp[comp];
      default: vop = cp[comp];
    endcase

    case (region)
      RG_AB:   ev = ab[comp];
      RG_AC:   ev = ac[comp];
      RG_BC:   ev = bc[comp];
      RG_FACE: ev = fsel ? ac[comp] : ab[comp];
      default: ev = ab[comp];
    endcase
    emag = ev[CW-1] ? (CW'(0) - ev) : ev;
    rnd  = mrsp.res[63:0] + 64'h0000_0000_2000_0000;
    rr   = PW'(rnd[30 +: CW+2]);

    pcur = p[comp];
    if (pcur < PMIN)      pc = CMIN;
    else if (pcur > PMAX) pc = CMAX;
    else                  pc = pcur[CW-1:0];
    diff = (CW+1)'(pc) - (CW+1)'(qv[comp]);
    dmag = diff[CW] ? ((CW+1)'(0) - diff) : diff;
    m34  = 34'(dmag);
    sat  = |m34[33:32];
    sq   = sat ? '1 : mrsp.res[63:0];
    s65  = {1'b0, sum_sq} + {1'b0, sq};
    dsum = ((comp == 2'd0) ? 64'sd0 : dacc) + mrsp.res[63:0];

    mreq.start = !pend && (state == ST_DOT || state == ST_VPROD || state == ST_DIV ||
                           state == ST_ALONG || state == ST_DIST);
    mreq.op    = (state == ST_DIV) ? MDU_DIV : MDU_MUL;
    case (state)
      ST_DOT: begin
        mreq.a = 128'(uop);
        mreq.b = 128'(vop);
      end
      ST_VPROD: begin
        case (step)
          3'd0:    begin mreq.a = 128'(d[0]); mreq.b = 128'(d[3]); end
          3'd1:    begin mreq.a = 128'(d[2]); mreq.b = 128'(d[1]); end
          3'd2:    begin mreq.a = 128'(d[4]); mreq.b = 128'(d[1]); end
          3'd3:    begin mreq.a = 128'(d[0]); mreq.b = 128'(d[5]); end
          3'd4:    begin mreq.a = 128'(d[2]); mreq.b = 128'(d[5]); end
          default: begin mreq.a = 128'(d[4]); mreq.b = 128'(d[3]); end
        endcase
      end
      ST_DIV: begin
        mreq.a = (region == RG_FACE) ? (fsel ? vv[0] : vv[1]) : num;
        mreq.b = den;
      end
      ST_ALONG: begin
        mreq.a = 128'(emag);
        mreq.b = 128'(tf[fsel]);
      end
      default: begin
        mreq.a = 128'(dmag);
        mreq.b = 128'(dmag);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend  <= 1'b0;
      done  <= 1'b0;
      step  <= '0;
      comp  <= '0;
      fsel  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (mreq.start) pend <= 1'b1;
      else if (mrsp.done) pend <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            av[0] <= item.first_vx[CW-1:0];
            av[1] <= item.first_vy[CW-1:0];
            av[2] <= item.first_vz[CW-1:0];
            bv[0] <= item.second_vx[CW-1:0];
            bv[1] <= item.second_vy[CW-1:0];
            bv[2] <= item.second_vz[CW-1:0];
            cv[0] <= item.third_vx[CW-1:0];
            cv[1] <= item.third_vy[CW-1:0];
            cv[2] <= item.third_vz[CW-1:0];
            qv[0] <= query_x[CW-1:0];
            qv[1] <= query_y[CW-1:0];
            qv[2] <= query_z[CW-1:0];
            step  <= '0;
            comp  <= '0;
            fsel  <= 1'b0;
            state <= ST_DOT;
          end
        end
        ST_DOT: begin
          if (mrsp.done) begin
            if (comp == 2'd2) begin
              d[step] <= dsum;
              comp    <= '0;
              if (step == 3'd5) begin
                step  <= '0;
                state <= ST_VPROD;
              end else begin
                step <= step + 3'd1;
              end
            end else begin
              dacc <= dsum;
              comp <= comp + 2'd1;
            end
          end
        end
        ST_VPROD: begin
          if (mrsp.done) begin
            if (!step[0]) wacc <= mrsp.res;
            else vv[step[2:1]] <= wacc - mrsp.res;
            if (step == 3'd5) state <= ST_REGION;
            else step <= step + 3'd1;
          end
        end
        ST_REGION: begin
          region <= rg;
          for (int i = 0; i < 3; i++) begin
            if (rg == RG_B || rg == RG_BC) p[i] <= PW'(bv[i]);
            else if (rg == RG_C)           p[i] <= PW'(cv[i]);
            else                           p[i] <= PW'(av[i]);
          end
          comp   <= '0;
          fsel   <= 1'b0;
          sum_sq <= '0;
          if (rg == RG_A || rg == RG_B || rg == RG_C) state <= ST_DIST;
          else state <= ST_PREP;
        end
        ST_PREP: begin
          case (region)
            RG_AB: begin
              num <= 128'(d[0]);
              den <= 128'(d[0] - d[2]);
            end
            RG_AC: begin
              num <= 128'(d[1]);
              den <= 128'(d[1] - d[5]);
            end
            RG_BC: begin
              num <= 128'(e43);
              den <= 128'(e43 + e56);
            end
            default: begin
              num <= vv[1];
              den <= vv[0] + vv[1] + vv[2];
            end
          endcase
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (mrsp.done) begin
            tf[fsel] <= mrsp.res[32:0];
            if (region == RG_FACE && !fsel) begin
              fsel <= 1'b1;
            end else begin
              fsel  <= 1'b0;
              comp  <= '0;
              state <= ST_ALONG;
            end
          end
        end
        ST_ALONG: begin
          if (mrsp.done) begin
            if (ev[CW-1]) p[comp] <= p[comp] - rr;
            else          p[comp] <= p[comp] + rr;
            if (comp == 2'd2) begin
              comp <= '0;
              if (region == RG_FACE && !fsel) begin
                fsel <= 1'b1;
              end else begin
                fsel   <= 1'b0;
                sum_sq <= '0;
                state  <= ST_DIST;
              end
            end else begin
              comp <= comp + 2'd1;
            end
          end
        end
        ST_DIST: begin
          if (mrsp.done) begin
            sum_sq   <= s65[64] ? '1 : s65[63:0];
            po[comp] <= pc;
            if (comp == 2'd2) begin
              comp  <= '0;
              done  <= 1'b1;
              state <= ST_IDLE;
            end else begin
              comp <= comp + 2'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign near.px      = 32'(po[0]);
  assign near.py      = 32'(po[1]);
  assign near.pz      = 32'(po[2]);
  assign near.dist_sq = sum_sq;

endmodule

// ----- src/nearest_point_on_triangle_stream.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_point_on_triangle_stream
// Running nearest point to a configured query over a stream of triangles.
// ----------------------------------------------------------------------------
// Usage:
//   triangle (sink): one item per triangle, three vertices in signed Q16.16,
//   mesh and triangle ids, and start_query to drop the running best first.
//   nearest (source): one item per triangle with shrunk, the current best
//   point, its squared distance (Q32.32, saturating), ids and found.
//   APB port: query_x/y/z at byte addresses 0, 4 and 8; write only while idle.
// Timing:
//   one triangle is in work at a time; ready is low from accept until its
//   item is loaded into the output register. Work is longest for the face,
//   shorter for an edge and shortest for a vertex region, as every product
//   and fraction divide runs in turn on the single multiply/divide unit.
//   The output register lets a new triangle enter while a result waits.
// Reset: query returns to the origin, the running best to all-ones distance.
// Stall: a finished result waits in the core until the output register frees.
// ----------------------------------------------------------------------------
module nearest_point_on_triangle_stream #(
  parameter int COORD_BITS   = npt_pkg::COORD_BITS_DEF,
  parameter int MESH_ID_BITS = npt_pkg::MESH_ID_BITS_DEF,
  parameter int TRI_ID_BITS  = npt_pkg::TRI_ID_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  npt_stream_if.sink                        triangle,
  npt_stream_if.source                      nearest,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [npt_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import npt_pkg::*;

  localparam int MB = (MESH_ID_BITS < 16) ? MESH_ID_BITS : 16;
  localparam int TB = (TRI_ID_BITS < 24) ? TRI_ID_BITS : 24;
  localparam logic [15:0] MESH_MASK = 16'((33'd1 << MB) - 33'd1);
  localparam logic [23:0] TRI_MASK  = 24'((33'd1 << TB) - 33'd1);

  logic [31:0] query_x;
  logic [31:0] query_y;
  logic [31:0] query_z;
  cfg_reg_t    reg_sel;
  logic        cfg_wr;

  logic        busy;
  logic        have;
  logic        accept;
  logic        commit;
  logic        start_q;
  logic [15:0] mesh_q;
  logic [23:0] tri_q;

  logic [63:0]        run_dist_sq;
  logic signed [31:0] run_px;
  logic signed [31:0] run_py;
  logic signed [31:0] run_pz;
  logic [15:0]        run_mesh;
  logic [23:0]        run_tri;
  logic               run_found;
  logic [63:0]        base_dist;
  logic               better;

  logic      core_done;
  near_t     near;
  res_item_t res_q;
  logic      res_valid;

  npt_core #(.COORD_BITS(COORD_BITS)) u_core (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .item    (triangle.data),
    .query_x (query_x),
    .query_y (query_y),
    .query_z (query_z),
    .done    (core_done),
    .near    (near)
  );

  assign pready = 1'b1;
  assign reg_sel = cfg_reg_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_sel)
      REG_QUERY_X: prdata = query_x;
      REG_QUERY_Y: prdata = query_y;
      REG_QUERY_Z: prdata = query_z;
      default:     prdata = '0;
    endcase
  end

  assign triangle.ready = !busy;
  assign accept    = triangle.valid && !busy;
  assign commit    = have && (!res_valid || nearest.ready);
  assign base_dist = start_q ? '1 : run_dist_sq;
  assign better    = near.dist_sq < base_dist;

  assign nearest.valid = res_valid;
  assign nearest.data  = res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_x     <= '0;
      query_y     <= '0;
      query_z     <= '0;
      busy        <= 1'b0;
      have        <= 1'b0;
      res_valid   <= 1'b0;
      run_dist_sq <= '1;
      run_px      <= '0;
      run_py      <= '0;
      run_pz      <= '0;
      run_mesh    <= '0;
      run_tri     <= '0;
      run_found   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (reg_sel)
          REG_QUERY_X: query_x <= 32'(signed'(pwdata[COORD_BITS-1:0]));
          REG_QUERY_Y: query_y <= 32'(signed'(pwdata[COORD_BITS-1:0]));
          REG_QUERY_Z: query_z <= 32'(signed'(pwdata[COORD_BITS-1:0]));
          default: ;
        endcase
      end

      if (accept) begin
        busy    <= 1'b1;
        start_q <= triangle.data.start_query;
        mesh_q  <= triangle.data.mesh_id & MESH_MASK;
        tri_q   <= triangle.data.tri_id & TRI_MASK;
      end

      if (core_done) have <= 1'b1;

      if (commit) begin
        have      <= 1'b0;
        busy      <= 1'b0;
        res_valid <= 1'b1;
        res_q.shrunk <= better;
        if (better) begin
          run_dist_sq        <= near.dist_sq;
          run_px             <= near.px;
          run_py             <= near.py;
          run_pz             <= near.pz;
          run_mesh           <= mesh_q;
          run_tri            <= tri_q;
          run_found          <= 1'b1;
          res_q.best_dist_sq <= near.dist_sq;
          res_q.best_px      <= near.px;
          res_q.best_py      <= near.py;
          res_q.best_pz      <= near.pz;
          res_q.best_mesh    <= mesh_q;
          res_q.best_tri     <= tri_q;
          res_q.found        <= 1'b1;
        end else if (start_q) begin
          run_dist_sq        <= '1;
          run_px             <= '0;
          run_py             <= '0;
          run_pz             <= '0;
          run_mesh           <= '0;
          run_tri            <= '0;
          run_found          <= 1'b0;
          res_q.best_dist_sq <= '1;
          res_q.best_px      <= '0;
          res_q.best_py      <= '0;
          res_q.best_pz      <= '0;
          res_q.best_mesh    <= '0;
          res_q.best_tri     <= '0;
          res_q.found        <= 1'b0;
        end else begin
          res_q.best_dist_sq <= run_dist_sq;
          res_q.best_px      <= run_px;
          res_q.best_py      <= run_py;
          res_q.best_pz      <= run_pz;
          res_q.best_mesh    <= run_mesh;
          res_q.best_tri     <= run_tri;
          res_q.found        <= run_found;
        end
      end else if (nearest.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    core_done |-> (busy && !have))
    else $error("core finished with no triangle in work");

  a_accept_holds: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy && !have))
    else $error("accepted triangle not held in work");

  a_shrunk_found: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_q.shrunk) |-> (res_q.found && res_q.best_dist_sq != '1))
    else $error("shrunk result without a found best");
`endif

endmodule
